>>> rtl/garc_pkg.sv
// garc_pkg: shared types and codes for the guest access range checker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package garc_pkg;

  localparam logic [1:0] CMD_LOAD_MAP  = 2'd0;
  localparam logic [1:0] CMD_LOAD_PREP = 2'd1;
  localparam logic [1:0] CMD_CHECK     = 2'd2;
  localparam logic [1:0] CMD_EXEC      = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_UNAVAILABLE = 3'd1;
  localparam logic [2:0] ST_OVERFLOW    = 3'd2;
  localparam logic [2:0] ST_DENIED      = 3'd3;
  localparam logic [2:0] ST_UNMAPPED    = 3'd4;

  localparam logic [1:0] REG_MEM_AVAIL  = 2'd0;
  localparam logic [1:0] REG_STACK_BASE = 2'd1;
  localparam logic [1:0] REG_STACK_SIZE = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic start;      // latch item, clear scan accumulators
    logic map_step;   // evaluate one mapping slot
    logic prep_step;  // evaluate one prepared slot
    logic advance;    // close chunk, move cursor
    logic finish;     // drive result
  } garc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic map_last;
    logic prep_last;
    logic early_done;   // result known right after start
    logic scan_only;    // execute query: mapping scan only
    logic map_fail;     // no mapping coverage
    logic prep_fail;    // no prepared coverage
    logic walk_done;    // range fully covered or overflow
  } garc_sts_t;

endpackage

>>> rtl/guest_access_range_checker.sv
// guest_access_range_checker: top level, config registers plus controller and datapath.
// Depends on garc_pkg, garc_ctrl, garc_datapath.
//
//  channel  | handshake             | beat
//  command  | start / busy          | cmd, entry_*, access_*
//  config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  result   | done_o strobe         | status, fault, checked_bytes, executable
//
// Loads and early outcomes skip the table scans. An execute query scans the mapping
// table only. A check walks chunks; each chunk scans the mapping table then the
// prepared table one slot per cycle through one span unit, then closes the chunk.
// Reset clears valid bits and config. The result strobe lasts one cycle; the
// receiver cannot stall it.
`timescale 1ns / 1ps
module guest_access_range_checker #(
  parameter int NUM_MAPPINGS = 16,
  parameter int NUM_PREPARED = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  entry_index_i,
  input  logic [63:0] entry_base_i,
  input  logic [63:0] entry_size_i,
  input  logic [2:0]  entry_perms_i,
  input  logic        entry_valid_i,
  input  logic [63:0] access_address_i,
  input  logic [31:0] access_length_i,
  input  logic        access_write_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic        has_fault_address_o,
  output logic [63:0] fault_address_o,
  output logic [31:0] checked_bytes_o,
  output logic        executable_o
);

  logic        mem_avail_q;
  logic [63:0] stack_base_q, stack_size_q;
  garc_pkg::garc_cmd_t cmd;
  garc_pkg::garc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_avail_q  <= 1'b0;
      stack_base_q <= '0;
      stack_size_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        garc_pkg::REG_MEM_AVAIL:  mem_avail_q  <= cfg_data_i[0];
        garc_pkg::REG_STACK_BASE: stack_base_q <= cfg_data_i;
        garc_pkg::REG_STACK_SIZE: stack_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  garc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .cmd_o(cmd), .sts_i(sts)
  );

  garc_datapath #(.NumMappings(NUM_MAPPINGS), .NumPrepared(NUM_PREPARED)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .mem_avail_i(mem_avail_q), .stack_base_i(stack_base_q), .stack_size_i(stack_size_q),
    .cmd_in_i(cmd_i), .entry_index_i, .entry_base_i, .entry_size_i, .entry_perms_i,
    .entry_valid_i, .access_address_i, .access_length_i, .access_write_i,
    .result_valid_o(done_o), .status_o, .has_fault_address_o, .fault_address_o,
    .checked_bytes_o, .executable_o
  );

endmodule

>>> rtl/garc_datapath.sv
// garc_datapath: region tables, cursor and chunk arithmetic of the checker.
// Depends on garc_pkg; sequenced by garc_ctrl.
`timescale 1ns / 1ps
module garc_datapath #(
  parameter int NumMappings = 16,
  parameter int NumPrepared = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  garc_pkg::garc_cmd_t  cmd_i,
  output garc_pkg::garc_sts_t  sts_o,
  input  logic                 mem_avail_i,
  input  logic [63:0]          stack_base_i,
  input  logic [63:0]          stack_size_i,
  input  logic [1:0]           cmd_in_i,
  input  logic [3:0]           entry_index_i,
  input  logic [63:0]          entry_base_i,
  input  logic [63:0]          entry_size_i,
  input  logic [2:0]           entry_perms_i,
  input  logic                 entry_valid_i,
  input  logic [63:0]          access_address_i,
  input  logic [31:0]          access_length_i,
  input  logic                 access_write_i,
  output logic                 result_valid_o,
  output logic [2:0]           status_o,
  output logic                 has_fault_address_o,
  output logic [63:0]          fault_address_o,
  output logic [31:0]          checked_bytes_o,
  output logic                 executable_o
);

  localparam int MapW  = (NumMappings > 1) ? $clog2(NumMappings) : 1;
  localparam int PrepW = (NumPrepared > 1) ? $clog2(NumPrepared) : 1;

  logic [63:0] map_base_q [NumMappings];
  logic [63:0] map_size_q [NumMappings];
  logic [2:0]  map_perms_q [NumMappings];
  logic [NumMappings-1:0] map_valid_q;
  logic [63:0] prep_base_q [NumPrepared];
  logic [63:0] prep_size_q [NumPrepared];
  logic [2:0]  prep_perms_q [NumPrepared];
  logic [NumPrepared-1:0] prep_valid_q;

  logic [1:0]  op_q;
  logic [63:0] cursor_q, cursor_d;
  logic [32:0] remain_q, remain_d;
  logic [31:0] len_q;
  logic [2:0]  need_q;
  logic [MapW:0]  mi_q;
  logic [PrepW:0] pi_q;
  logic [63:0] best_q, prep_q;
  logic        denied_q, pdenied_q, exec_q;

  logic [2:0]  st_q;
  logic        hf_q, rv_q;
  logic [63:0] fa_q;
  logic [31:0] cb_q;
  logic        ex_q;

  // shared span unit: bytes from cursor to end of region, zero if outside
  logic [63:0] sp_base, sp_size, sp_off, span;
  logic [2:0]  sp_perms;
  logic        sp_valid;
  always_comb begin
    if (cmd_i.map_step) begin
      sp_base  = map_base_q[mi_q[MapW-1:0]];
      sp_size  = map_size_q[mi_q[MapW-1:0]];
      sp_perms = map_perms_q[mi_q[MapW-1:0]];
      sp_valid = map_valid_q[mi_q[MapW-1:0]];
    end else begin
      sp_base  = prep_base_q[pi_q[PrepW-1:0]];
      sp_size  = prep_size_q[pi_q[PrepW-1:0]];
      sp_perms = prep_perms_q[pi_q[PrepW-1:0]];
      sp_valid = prep_valid_q[pi_q[PrepW-1:0]];
    end
    sp_off = cursor_q - sp_base;
    span = ((cursor_q >= sp_base) && (sp_off < sp_size)) ? sp_size - sp_off : 64'd0;
  end

  logic [63:0] stk_off, stk_span, best_all, chunk;
  logic        len_zero, wrap;
  logic [63:0] len_m1;
  always_comb begin
    stk_off  = cursor_q - stack_base_i;
    stk_span = ((cursor_q >= stack_base_i) && (stk_off < stack_size_i)) ?
               stack_size_i - stk_off : 64'd0;
    best_all = (stk_span > best_q) ? stk_span : best_q;
    chunk    = (best_all < prep_q) ? best_all : prep_q;
    if ({31'd0, remain_q} < chunk) chunk = {31'd0, remain_q};
    len_zero = (access_length_i == 32'd0);
    len_m1   = {32'd0, access_length_i - 32'd1};
    wrap     = access_address_i > (~64'd0 - len_m1);
  end

  assign remain_d = remain_q - chunk[32:0];
  assign cursor_d = cursor_q + chunk;

  assign sts_o.map_last   = (mi_q == (MapW+1)'(NumMappings - 1));
  assign sts_o.prep_last  = (pi_q == (PrepW+1)'(NumPrepared - 1));
  assign sts_o.early_done = (op_q == garc_pkg::CMD_LOAD_MAP) ||
                            (op_q == garc_pkg::CMD_LOAD_PREP) ||
                            ((op_q == garc_pkg::CMD_CHECK) &&
                             (!mem_avail_i || (len_q == 32'd0) ||
                              (st_q == garc_pkg::ST_OVERFLOW)));
  assign sts_o.scan_only  = (op_q == garc_pkg::CMD_EXEC);
  assign sts_o.map_fail   = (best_all == 64'd0);
  assign sts_o.prep_fail  = (prep_q == 64'd0);
  assign sts_o.walk_done  = (remain_d == 33'd0) || (cursor_q > ~64'd0 - chunk);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_valid_q  <= '0;
      prep_valid_q <= '0;
      rv_q         <= 1'b0;
    end else begin
      rv_q <= cmd_i.finish;
      if (cmd_i.start && cmd_in_i == garc_pkg::CMD_LOAD_MAP &&
          {28'd0, entry_index_i} < 32'(NumMappings))
        map_valid_q[MapW'(entry_index_i)] <= entry_valid_i;
      if (cmd_i.start && cmd_in_i == garc_pkg::CMD_LOAD_PREP &&
          {28'd0, entry_index_i} < 32'(NumPrepared))
        prep_valid_q[PrepW'(entry_index_i)] <= entry_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      if (cmd_in_i == garc_pkg::CMD_LOAD_MAP &&
          {28'd0, entry_index_i} < 32'(NumMappings)) begin
        map_base_q[MapW'(entry_index_i)]  <= entry_base_i;
        map_size_q[MapW'(entry_index_i)]  <= entry_size_i;
        map_perms_q[MapW'(entry_index_i)] <= entry_perms_i;
      end
      if (cmd_in_i == garc_pkg::CMD_LOAD_PREP &&
          {28'd0, entry_index_i} < 32'(NumPrepared)) begin
        prep_base_q[PrepW'(entry_index_i)]  <= entry_base_i;
        prep_size_q[PrepW'(entry_index_i)]  <= entry_size_i;
        prep_perms_q[PrepW'(entry_index_i)] <= entry_perms_i;
      end
      op_q     <= cmd_in_i;
      cursor_q <= access_address_i;
      remain_q <= {1'b0, access_length_i};
      len_q    <= access_length_i;
      need_q   <= (cmd_in_i == garc_pkg::CMD_EXEC) ? 3'b100 :
                  (access_write_i ? 3'b010 : 3'b001);
      mi_q <= '0; pi_q <= '0;
      best_q <= '0; prep_q <= '0;
      denied_q <= 1'b0; pdenied_q <= 1'b0; exec_q <= 1'b0;
      // precompute the early result; overflow marks the status register
      st_q <= garc_pkg::ST_OK; hf_q <= 1'b0; fa_q <= '0; cb_q <= '0; ex_q <= 1'b0;
      if (cmd_in_i == garc_pkg::CMD_CHECK) begin
        if (!mem_avail_i) st_q <= garc_pkg::ST_UNAVAILABLE;
        else if (!len_zero && wrap) begin
          st_q <= garc_pkg::ST_OVERFLOW; hf_q <= 1'b1; fa_q <= access_address_i;
        end
      end
    end
    if (cmd_i.map_step) begin
      mi_q <= mi_q + 1'b1;
      if (sp_valid && span != 64'd0) begin
        if ((sp_perms & need_q) == 3'b000) denied_q <= 1'b1;
        else begin
          if (span > best_q) best_q <= span;
          exec_q <= 1'b1;
        end
      end
    end
    if (cmd_i.prep_step) begin
      pi_q <= pi_q + 1'b1;
      if (sp_valid && span != 64'd0) begin
        if ((sp_perms & need_q) == 3'b000) pdenied_q <= 1'b1;
        else if (span > prep_q) prep_q <= span;
      end
    end
    if (cmd_i.advance) begin
      remain_q <= remain_d;
      cursor_q <= cursor_d;
      mi_q <= '0; pi_q <= '0;
      best_q <= '0; prep_q <= '0;
      denied_q <= 1'b0; pdenied_q <= 1'b0;
    end
    if (cmd_i.finish) begin
      if (op_q == garc_pkg::CMD_EXEC) ex_q <= exec_q & mem_avail_i;
      else if (op_q == garc_pkg::CMD_CHECK && st_q == garc_pkg::ST_OK &&
               mem_avail_i && len_q != 32'd0) begin
        // walk ended: decide between success, denial, gaps and overflow
        if (sts_o.map_fail) begin
          st_q <= denied_q ? garc_pkg::ST_DENIED : garc_pkg::ST_UNMAPPED;
          hf_q <= 1'b1; fa_q <= cursor_q;
        end else if (sts_o.prep_fail) begin
          st_q <= pdenied_q ? garc_pkg::ST_DENIED : garc_pkg::ST_UNAVAILABLE;
          hf_q <= 1'b1; fa_q <= cursor_q;
        end else if (remain_d != 33'd0) begin
          st_q <= garc_pkg::ST_OVERFLOW; hf_q <= 1'b1; fa_q <= cursor_q;
        end else cb_q <= len_q;
      end
    end
  end

  assign result_valid_o      = rv_q;
  assign status_o            = st_q;
  assign has_fault_address_o = hf_q;
  assign fault_address_o     = fa_q;
  assign checked_bytes_o     = cb_q;
  assign executable_o        = ex_q;

endmodule

>>> rtl/garc_ctrl.sv
// garc_ctrl: sequencer for table scans and chunk walk.
// Depends on garc_pkg; drives garc_datapath.
`timescale 1ns / 1ps
module garc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output garc_pkg::garc_cmd_t cmd_o,
  input  garc_pkg::garc_sts_t sts_i
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_MAP    = 6'b000100,
    S_PREP   = 6'b001000,
    S_CHUNK  = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.start = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = sts_i.early_done ? S_DONE : S_MAP;
      end
      S_MAP: begin
        cmd_o.map_step = 1'b1;
        // execute query needs the mapping scan only
        if (sts_i.map_last) state_d = sts_i.scan_only ? S_DONE : S_PREP;
      end
      S_PREP: begin
        cmd_o.prep_step = 1'b1;
        if (sts_i.prep_last) state_d = S_CHUNK;
      end
      S_CHUNK: begin
        // stop on a gap, on full coverage or on cursor wrap; else next chunk
        if (sts_i.map_fail || sts_i.prep_fail || sts_i.walk_done) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d = S_MAP;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> rtl/garc_checker.sv
// garc_checker: port-level assertions for the range checker.
// Depends on garc_pkg and guest_access_range_checker; attached by bind.
`timescale 1ns / 1ps
module garc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic        has_fault_address_o,
  input logic [31:0] checked_bytes_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept did not raise busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe too long");
  a_fault_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && has_fault_address_o |->
      status_o != garc_pkg::ST_OK && checked_bytes_o == 32'd0)
    else $error("fault with ok status");
endmodule

bind guest_access_range_checker garc_checker u_garc_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .status_o, .has_fault_address_o,
  .checked_bytes_o
);
